/* hw/rtl/mtn_pkg.sv */
// ----------------------------------------------------------------------------
// mtn_pkg
// shared types and constants for the markup tag nesting checker
// ----------------------------------------------------------------------------
package mtn_pkg;

  localparam int STATUS_W = 3;
  localparam int OPEN_W   = 6;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISMATCH     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CLOSE_EMPTY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NAME_LONG    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_DEEP     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNTERMINATED = 3'd5;

  // markup characters
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_GT    = 8'h3E;

  typedef struct packed {
    logic [OPEN_W-1:0]   open_tags;
    logic [STATUS_W-1:0] status;
  } mtn_result_t;

endpackage

/* hw/rtl/mtn_parser.sv */
// ----------------------------------------------------------------------------
// mtn_parser
// tag parser with name stack; next-state read prefetch of both stores
// ----------------------------------------------------------------------------
module mtn_parser #(
  parameter int MAX_DEPTH = 32,
  parameter int MAX_NAME  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_take,
  input  logic [7:0]           in_ch,
  input  logic                 in_last,
  output logic                 res_valid,
  output mtn_pkg::mtn_result_t res
);
  import mtn_pkg::*;

  localparam int DW    = $clog2(MAX_DEPTH + 1);
  localparam int IW    = $clog2(MAX_NAME + 1);
  localparam int TW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int SLOTS = MAX_DEPTH * MAX_NAME;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [3:0] {
    MODE_OUT   = 4'b0001,
    MODE_LT    = 4'b0010,
    MODE_OPEN  = 4'b0100,
    MODE_CLOSE = 4'b1000
  } mtn_mode_t;

  mtn_mode_t           mode_r, mode_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [DW-1:0]       depth_r, depth_nxt;
  logic                eq_r, eq_nxt;
  logic [STATUS_W-1:0] err_r, err_nxt;

  logic [7:0]          name_mem [SLOTS];
  logic [IW-1:0]       len_mem  [MAX_DEPTH];
  logic [7:0]          st_rd_r;
  logic [IW-1:0]       len_rd_r;

  logic                st_we, len_we;
  logic [AW-1:0]       st_wa, st_ra;
  logic [TW-1:0]       len_wa, len_ra;
  logic                rd_en;
  logic [31:0]         wa_full, ra_full;
  logic [TW-1:0]       top_nxt;

  logic                do_name, do_end, is_close;
  mtn_mode_t           mode_mid;
  logic [DW-1:0]       depth_mid;
  logic [STATUS_W-1:0] err_mid;

  // one byte through the parser
  always_comb begin
    mode_mid  = mode_r;
    idx_nxt   = idx_r;
    depth_mid = depth_r;
    eq_nxt    = eq_r;
    err_mid   = err_r;
    st_we     = 1'b0;
    len_we    = 1'b0;
    do_name   = 1'b0;
    do_end    = 1'b0;
    is_close  = (mode_r == MODE_CLOSE);

    if (in_take && (err_r == ST_OK)) begin
      case (mode_r)
        MODE_OUT: begin
          if (in_ch == CH_LT) begin
            mode_mid = MODE_LT;
            idx_nxt  = '0;
            eq_nxt   = 1'b1;
          end
        end
        MODE_LT: begin
          if (in_ch == CH_SLASH) begin
            mode_mid = MODE_CLOSE;
          end else begin
            mode_mid = MODE_OPEN;
            do_end   = (in_ch == CH_GT);
            do_name  = (in_ch != CH_GT);
          end
        end
        MODE_OPEN, MODE_CLOSE: begin
          do_end  = (in_ch == CH_GT);
          do_name = (in_ch != CH_GT);
        end
        default: begin
          mode_mid = MODE_OUT;
        end
      endcase
    end

    if (do_name) begin
      if (idx_r >= IW'(MAX_NAME)) begin
        err_mid = ST_NAME_LONG;
      end else begin
        if (!is_close) begin
          st_we = (depth_r < DW'(MAX_DEPTH));
        end else if (depth_r != '0) begin
          if ((idx_r >= len_rd_r) || (st_rd_r != in_ch)) eq_nxt = 1'b0;
        end else begin
          eq_nxt = 1'b0;
        end
        idx_nxt = idx_r + 1'b1;
      end
    end

    if (do_end) begin
      if (is_close) begin
        if (depth_r == '0) begin
          err_mid = ST_CLOSE_EMPTY;
        end else if (!eq_r || (idx_r != len_rd_r)) begin
          err_mid = ST_MISMATCH;
        end else begin
          depth_mid = depth_r - 1'b1;
        end
      end else begin
        if (depth_r >= DW'(MAX_DEPTH)) begin
          err_mid = ST_TOO_DEEP;
        end else begin
          len_we    = 1'b1;
          depth_mid = depth_r + 1'b1;
        end
      end
      mode_mid = MODE_OUT;
      idx_nxt  = '0;
      eq_nxt   = 1'b1;
    end

    // result on the last byte, then back to the reset state
    res_valid = in_take && in_last;
    res.open_tags = OPEN_W'(depth_mid);
    if (err_mid != ST_OK)         res.status = err_mid;
    else if (mode_mid != MODE_OUT) res.status = ST_UNTERMINATED;
    else                           res.status = ST_OK;

    mode_nxt  = mode_mid;
    depth_nxt = depth_mid;
    err_nxt   = err_mid;
    if (res_valid) begin
      mode_nxt  = MODE_OUT;
      idx_nxt   = '0;
      depth_nxt = '0;
      eq_nxt    = 1'b1;
      err_nxt   = ST_OK;
    end
  end

  // store addresses: write at the current slot, read the slot of the next byte
  always_comb begin
    top_nxt = TW'(depth_nxt - 1'b1);
    wa_full = 32'(depth_r[TW-1:0]) * 32'(MAX_NAME) + 32'(idx_r);
    ra_full = 32'(top_nxt) * 32'(MAX_NAME) + 32'(idx_nxt);
    st_wa   = wa_full[AW-1:0];
    st_ra   = ra_full[AW-1:0];
    len_wa  = depth_r[TW-1:0];
    len_ra  = top_nxt;
    rd_en   = (depth_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (st_we) name_mem[st_wa] <= in_ch;
    if (rd_en && (idx_nxt < IW'(MAX_NAME))) st_rd_r <= name_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_wa] <= idx_r;
    if (rd_en) begin
      // a push reads back the length it writes in the same cycle
      if (len_we && (len_wa == len_ra)) len_rd_r <= idx_r;
      else                              len_rd_r <= len_mem[len_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_OUT;
      idx_r   <= '0;
      depth_r <= '0;
      eq_r    <= 1'b1;
      err_r   <= ST_OK;
    end else begin
      mode_r  <= mode_nxt;
      idx_r   <= idx_nxt;
      depth_r <= depth_nxt;
      eq_r    <= eq_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

/* hw/rtl/mtn_out_reg.sv */
// ----------------------------------------------------------------------------
// mtn_out_reg
// result register between the parser and the output channel
// ----------------------------------------------------------------------------
module mtn_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  mtn_pkg::mtn_result_t res,
  output logic                 take_ok,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mtn_pkg::mtn_result_t out_res
);
  import mtn_pkg::*;

  logic        valid_r;
  mtn_result_t res_r;

  assign take_ok   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take_ok) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_ok && res_valid) res_r <= res;
  end

endmodule

/* hw/rtl/markup_tag_nesting_checker.sv */
// ----------------------------------------------------------------------------
// markup_tag_nesting_checker
// balanced tag checker over a byte stream with a bounded name stack
// ----------------------------------------------------------------------------
// usage
//   in_*  : one markup byte per word in in_tdata, in_tlast on the final
//           byte of a document
//   out_* : one word per document, sent for the byte marked last, holding
//           the status code and the number of tags still open
// throughput: one byte per cycle while in_tready is high, with no bubbles between
//   documents; each byte needs one name store read and one compare, and the
//   read for the next byte is issued from the parser's next state
// latency: the result word is valid the cycle after its last byte is taken
// stall: the result sits in an output register; while it waits and
//   out_tready is low, in_tready drops, otherwise bytes keep flowing
// reset: rst_n low clears the parser to outside any tag with an empty stack
//   and no error, and empties the output register; the name stores are not
//   cleared, only entries below a pushed length are ever compared
// ----------------------------------------------------------------------------
module markup_tag_nesting_checker #(
  parameter int MAX_DEPTH = 32,
  parameter int MAX_NAME  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // last byte of the document
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [2:0] status, [8:3] open_tags, [15:9] zero
);
  import mtn_pkg::*;

  logic        take;
  logic        res_valid;
  mtn_result_t res;
  mtn_result_t out_res;

  // a byte is taken when it is valid and the result register can absorb what it makes
  assign take = in_tvalid && in_tready;

  mtn_parser #(
    .MAX_DEPTH (MAX_DEPTH),
    .MAX_NAME  (MAX_NAME)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (take),
    .in_ch     (in_tdata),
    .in_last   (in_tlast),
    .res_valid (res_valid),
    .res       (res)
  );

  mtn_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .take_ok   (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // pack status lowest, then open_tags, then zero fill
  assign out_tdata = {7'd0, out_res.open_tags, out_res.status};

endmodule

/* tb/sv/markup_tag_nesting_checker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markup_tag_nesting_checker_tb
// self-checking bench for the markup tag nesting checker
// ----------------------------------------------------------------------------
// documents are streamed one byte per word into the block and every result
// word is compared with a behavioral copy of the tag parser kept in a small
// scoreboard class. a directed set of documents hits the corner cases, then
// random documents (mostly well-formed nesting, plus spoiled closes, stray
// closes, long names, deep stacks, cut-off tags and raw noise) run with
// random gaps on both sides and, twice, a long output hold-off
// ----------------------------------------------------------------------------
module markup_tag_nesting_checker_tb;
  import mtn_pkg::*;

  // block sizes, kept at the defaults of the design
  localparam int STACK_SLOTS = 32;
  localparam int NAME_BYTES  = 16;

  // generator bookkeeping: room past the block limits for deep and long tags
  localparam int GEN_SLOTS  = 40;
  localparam int GEN_NAME   = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_BYTES  = 430;
  localparam int RAND_DOCS   = 8;

  // parser position inside the byte stream
  typedef enum logic [1:0] {
    PM_TEXT,        // outside any tag
    PM_AFTER_LT,    // just took '<'
    PM_OPEN_NAME,   // inside an opening name
    PM_CLOSE_NAME   // inside a closing name
  } parse_mode_t;

  // flavors of random documents
  typedef enum int {
    DOC_CLEAN, DOC_MISMATCH, DOC_STRAY, DOC_LONG, DOC_DEEP, DOC_OPEN_END, DOC_NOISE
  } doc_kind_t;

  // --------------------------------------------------------------------------
  // scoreboard: tracks the tag stack from accepted bytes and checks verdicts
  // --------------------------------------------------------------------------
  class tag_nesting_board;
    logic [7:0]   name_mem [STACK_SLOTS][NAME_BYTES];
    logic [4:0]   name_len [STACK_SLOTS];
    logic [5:0]   depth;
    logic [4:0]   idx;
    parse_mode_t  mode;
    logic         same;
    logic [2:0]   err;
    mtn_result_t  verdicts_due[$];
    int           mismatches;
    int           docs_checked;
    int           bytes_seen;
    int           status_hits[6];

    function new();
      restart();
    endfunction

    // name bytes stay as they are, only bytes below a pushed length are read
    function void restart();
      depth = '0;
      idx   = '0;
      mode  = PM_TEXT;
      same  = 1'b1;
      err   = ST_OK;
    endfunction

    function void take_name(logic [7:0] ch);
      if (idx >= NAME_BYTES) begin
        err = ST_NAME_LONG;
        return;
      end
      if (mode == PM_OPEN_NAME) begin
        if (depth < STACK_SLOTS) name_mem[depth][idx] = ch;
      end else if (depth != 0) begin
        if (idx >= name_len[depth-1] || name_mem[depth-1][idx] != ch) same = 1'b0;
      end else begin
        same = 1'b0;
      end
      idx++;
    endfunction

    function void finish_tag();
      if (mode == PM_CLOSE_NAME) begin
        if (depth == 0) err = ST_CLOSE_EMPTY;
        else if (!same || idx != name_len[depth-1]) err = ST_MISMATCH;
        else depth--;
      end else begin
        if (depth >= STACK_SLOTS) err = ST_TOO_DEEP;
        else begin
          name_len[depth] = idx;
          depth++;
        end
      end
      mode = PM_TEXT;
      idx  = '0;
      same = 1'b1;
    endfunction

    function void advance_parser(logic [7:0] ch);
      case (mode)
        PM_TEXT: begin
          if (ch == CH_LT) begin
            mode = PM_AFTER_LT;
            idx  = '0;
            same = 1'b1;
          end
        end
        PM_AFTER_LT: begin
          if (ch == CH_SLASH) mode = PM_CLOSE_NAME;
          else begin
            mode = PM_OPEN_NAME;
            if (ch == CH_GT) finish_tag();
            else take_name(ch);
          end
        end
        default: begin
          if (ch == CH_GT) finish_tag();
          else take_name(ch);
        end
      endcase
    endfunction

    // called for every byte the block accepted
    function void note_byte(logic [7:0] ch, logic lst);
      mtn_result_t v;
      bytes_seen++;
      if (err == ST_OK) advance_parser(ch);
      if (lst) begin
        v.status    = (err == ST_OK && mode != PM_TEXT) ? ST_UNTERMINATED : err;
        v.open_tags = depth;
        verdicts_due = {verdicts_due, v};
        restart();
      end
    endfunction

    function void flag(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 10)
        $display("  mismatch on document %0d: %s expected %0d, got %0d",
                 docs_checked, what, want, got);
    endfunction

    // called for every result word the bench accepted
    function void check_verdict(logic [15:0] word);
      mtn_result_t got, want;
      got = word[8:0];
      docs_checked++;
      if (got.status < 6) status_hits[got.status]++;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("  result word %h arrived with no document pending", word);
        return;
      end
      want = verdicts_due.pop_front();
      if (got.status != want.status) flag("status", want.status, got.status);
      if (got.open_tags != want.open_tags) flag("open_tags", want.open_tags, got.open_tags);
      if (word[15:9] != '0) flag("padding", 0, word[15:9]);
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;    // [7:0] ch
  logic        in_tlast   = 1'b0;  // last byte of the document
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [2:0] status, [8:3] open_tags, [15:9] zero

  always #1 clk = ~clk;

  markup_tag_nesting_checker #(
    .MAX_DEPTH (STACK_SLOTS),
    .MAX_NAME  (NAME_BYTES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tag_nesting_board board;

  // shared pacing controls: no_idle turns off gaps on both sides, hold_req
  // asks the result side for one long hold-off
  bit no_idle  = 1'b0;
  bit hold_req = 1'b0;
  int rx_stall = 0;
  int rx_gap;

  // document under construction and the generator's own tag stack
  logic [7:0] doc_q[$];
  logic [7:0] gen_name [GEN_SLOTS][GEN_NAME];
  int         gen_len  [GEN_SLOTS];
  int         gen_d;

  // mostly back to back, sometimes a short pause, now and then a long one
  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // --------------------------------------------------------------------------
  // result side: checks accepted words and paces out_tready
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      // handshake seen with the values from before this edge
      if (out_tvalid && out_tready) board.check_verdict(out_tdata);
      if (hold_req) begin
        hold_req = 1'b0;
        rx_stall = HOLD_CYCLES;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        rx_gap = idle_gap();
        if (rx_gap == 0) begin
          out_tready <= 1'b1;
        end else begin
          rx_stall = rx_gap - 1;
          out_tready <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  // one byte, after an optional gap; returns at the edge that took it
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_byte(b, lst);
  endtask

  // appends one byte to the document under construction
  task automatic put_byte(input logic [7:0] b);
    doc_q = {doc_q, b};
  endtask

  // whole document, last flag on its final byte; an empty one goes as a space
  task automatic send_doc();
    if (doc_q.size() == 0) put_byte(8'h20);
    for (int i = 0; i < doc_q.size(); i++) send_byte(doc_q[i], i == doc_q.size() - 1);
  endtask

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic send_text(input string s);
    doc_q.delete();
    load_text(s);
    send_doc();
  endtask

  // --------------------------------------------------------------------------
  // random document builder
  // --------------------------------------------------------------------------
  // any byte but '>', and no '/' at the head of an opening name
  function automatic logic [7:0] name_byte(input bit head);
    logic [7:0] b;
    do b = $urandom_range(0, 255);
    while (b == CH_GT || (head && b == CH_SLASH));
    return b;
  endfunction

  function automatic int name_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 85) return $urandom_range(1, 5);
    if (r < 97) return $urandom_range(6, NAME_BYTES - 1);
    return NAME_BYTES;
  endfunction

  task automatic open_tag(input int len);
    logic [7:0] b;
    put_byte(CH_LT);
    for (int i = 0; i < len; i++) begin
      b = name_byte(i == 0);
      put_byte(b);
      if (gen_d < GEN_SLOTS && i < GEN_NAME) gen_name[gen_d][i] = b;
    end
    put_byte(CH_GT);
    if (gen_d < GEN_SLOTS) gen_len[gen_d] = (len < GEN_NAME) ? len : GEN_NAME;
    gen_d++;
  endtask

  // closes the top tag; spoil changes one byte, adds a byte or drops one;
  // with nothing open it sends a stray close with a random name
  task automatic close_tag(input bit spoil);
    int len, how, k;
    logic [7:0] b;
    put_byte(CH_LT);
    put_byte(CH_SLASH);
    if (gen_d == 0) begin
      repeat ($urandom_range(0, 4)) put_byte(name_byte(1'b0));
    end else begin
      gen_d--;
      len = (gen_d < GEN_SLOTS) ? gen_len[gen_d] : 0;
      how = spoil ? $urandom_range(0, 2) : 3;
      if (how != 1 && how != 3 && len == 0) how = 1;
      if (how == 2) len--;
      k = (how == 0) ? $urandom_range(0, len - 1) : -1;
      for (int i = 0; i < len; i++) begin
        b = gen_name[gen_d][i];
        if (i == k) begin
          b = b ^ (8'h01 << $urandom_range(0, 7));
          if (b == CH_GT) b = gen_name[gen_d][i] ^ 8'hFF;
        end
        put_byte(b);
      end
      if (how == 1) put_byte(name_byte(1'b0));
    end
    put_byte(CH_GT);
  endtask

  function automatic doc_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return DOC_CLEAN;
    if (r < 62) return DOC_MISMATCH;
    if (r < 68) return DOC_STRAY;
    if (r < 74) return DOC_LONG;
    if (r < 78) return DOC_DEEP;
    if (r < 86) return DOC_OPEN_END;
    return DOC_NOISE;
  endfunction

  // builds one document into doc_q; every kind but noise is a nesting walk
  // with random names and text; stray documents plant up to two faults, others at most one
  task automatic make_doc(input doc_kind_t kind);
    int steps, cap, fault_at, r;
    logic [7:0] b;
    doc_q.delete();
    gen_d = 0;
    if (kind == DOC_NOISE) begin
      // raw bytes leaning on the markup characters
      repeat ($urandom_range(1, 40)) begin
        r = $urandom_range(0, 99);
        if (r < 20) b = CH_LT;
        else if (r < 30) b = CH_SLASH;
        else if (r < 45) b = CH_GT;
        else b = $urandom_range(0, 255);
        put_byte(b);
      end
      return;
    end
    cap      = (kind == DOC_DEEP) ? STACK_SLOTS + 3 : $urandom_range(1, 6);
    steps    = $urandom_range(1, 16);
    fault_at = $urandom_range(0, steps - 1);
    if (kind == DOC_STRAY && $urandom_range(0, 1)) close_tag(1'b0);
    // deep documents fill the stack to the brim or just past it
    if (kind == DOC_DEEP)
      repeat (STACK_SLOTS + $urandom_range(0, 2)) open_tag($urandom_range(0, 2));
    for (int i = 0; i < steps; i++) begin
      if (i == fault_at && kind == DOC_MISMATCH) begin
        if (gen_d == 0) open_tag(name_size());
        close_tag(1'b1);
      end else if (i == fault_at && kind == DOC_LONG) begin
        open_tag($urandom_range(NAME_BYTES + 1, NAME_BYTES + 4));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40 && gen_d < cap) open_tag(name_size());
        else if (r < 75 && gen_d > 0) close_tag(1'b0);
        else begin
          // text between tags, never starting a tag
          repeat ($urandom_range(1, 3)) begin
            b = $urandom_range(0, 255);
            put_byte(b == CH_LT ? 8'h20 : b);
          end
        end
      end
    end
    if (kind == DOC_OPEN_END) begin
      // stream ends inside a tag
      put_byte(CH_LT);
      if ($urandom_range(0, 1)) put_byte(CH_SLASH);
      repeat ($urandom_range(0, 3)) put_byte(name_byte(1'b0));
    end else if (kind == DOC_STRAY) begin
      // unwind everything and then one close too many
      while (gen_d > 0) close_tag(1'b0);
      close_tag(1'b0);
    end else if ($urandom_range(0, 9) < 7) begin
      while (gen_d > 0) close_tag(1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int rand_bytes;
    board = new();
    rand_bytes = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed documents
    send_text(" ");                       // empty document
    send_text("<a><b></b></a>");          // plain nesting
    send_text("<></>");                   // empty names open and close
    send_text("x/> <p>hi</p> >/");        // markup characters in text
    send_text("</x>");                    // close with nothing open
    send_text("<a></a></a>");             // close after the stack emptied
    send_text("<ab></ac>");               // differs in a byte
    send_text("<ab></a>");                // closing name shorter
    send_text("<a></ab>");                // closing name longer
    send_text("<0123456789abcdef></0123456789abcdef>");  // longest legal name
    send_text("<0123456789abcdefg>");     // one byte too many
    send_text("<a><b>");                  // tags left open
    send_text("<ab");                     // cut off in an opening name
    send_text("<");                       // cut off right after '<'
    send_text("<a></a");                  // cut off in a closing name
    send_text("<a<b></a<b>");             // '<' inside a name
    send_text("</x><a>");                 // bytes after an error are ignored
    // stack exactly full, then one level past it
    doc_q.delete();
    repeat (STACK_SLOTS) load_text("<>");
    send_doc();
    doc_q.delete();
    repeat (STACK_SLOTS + 1) load_text("<>");
    load_text("</>");
    send_doc();
    // extreme byte values inside names and in text
    doc_q = '{CH_LT, 8'h00, 8'hFF, 8'h80, 8'h7F, CH_GT,
              CH_LT, CH_SLASH, 8'h00, 8'hFF, 8'h80, 8'h7F, CH_GT, 8'hFF};
    send_doc();
    doc_q = '{CH_LT, 8'hFF, CH_GT, CH_LT, CH_SLASH, 8'hFE, CH_GT, 8'h00};
    send_doc();

    // random documents; bursts without gaps now and then, and a long
    // output hold-off twice so the output register fills and bytes back up
    for (int doc_no = 0; rand_bytes < RAND_BYTES || doc_no < RAND_DOCS; doc_no++) begin
      if (doc_no % 4 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (doc_no == 2 || doc_no == 6) begin
        no_idle  = 1'b1;
        hold_req = 1'b1;
      end
      make_doc(pick_kind());
      rand_bytes += doc_q.size();
      send_doc();
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    no_idle   = 1'b0;

    // drain, then give a stray word a chance to show up
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d documents, %0d bytes; ok %0d, mismatch %0d, stray close %0d,",
             board.docs_checked, board.bytes_seen, board.status_hits[ST_OK],
             board.status_hits[ST_MISMATCH], board.status_hits[ST_CLOSE_EMPTY]);
    $display("  long name %0d, too deep %0d, cut off %0d; %0d mismatches",
             board.status_hits[ST_NAME_LONG], board.status_hits[ST_TOO_DEEP],
             board.status_hits[ST_UNTERMINATED], board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #1000000;
    $display("watchdog expired with %0d results outstanding", board.pending());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
